// ===== design/cs_pkg.sv =====
package cs_pkg;

  localparam int PIXEL_BITS  = 8;
  localparam int NUM_W       = 2 * PIXEL_BITS;
  localparam int CNT_W       = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PIXEL_BITS-1:0] MAX_CODE = '1;
  localparam logic [CNT_W-1:0]      LAST_STEP = CNT_W'(PIXEL_BITS - 1);

  typedef enum logic {
    REQ_MEASURE = 1'b0,
    REQ_MAP     = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                  req_type;
    logic [PIXEL_BITS-1:0] pixel_value;
    logic                  first_of_plane;
  } in_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] mapped_value;
    logic [PIXEL_BITS-1:0] limit_low;
    logic [PIXEL_BITS-1:0] limit_high;
    logic                  flat;
  } out_t;

  // One classified map transaction handed from the front to the back.
  typedef struct packed {
    logic                  need_div;
    logic [NUM_W-1:0]      num;
    logic [PIXEL_BITS-1:0] den;
    logic [PIXEL_BITS-1:0] quick;
    logic [PIXEL_BITS-1:0] lo;
    logic [PIXEL_BITS-1:0] hi;
    logic                  flat;
  } job_t;

endpackage

// ===== design/contrast_stretch_min_max.sv =====
// A measure transaction updates the limits in the cycle it is accepted and gives no result.
// A map transaction waits in the queue until the back takes it. A direct answer (flat or
// saturated) is registered as it is taken; otherwise the 8-step radix-2 divider runs first.
// The divider sets throughput: the back takes no job while it divides; busy rises when
// the two-entry queue in front of it is full. The receiver cannot stall the result strobe.
// Synchronous reset clears the limits to 255 and 0, empties the queue and idles the divider.
module contrast_stretch_min_max #(
  parameter int QUEUE_DEPTH = cs_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  cs_pkg::in_t  item,
  output logic         busy,
  output logic         result_valid,
  output cs_pkg::out_t result
);
  import cs_pkg::*;

  logic full;
  logic push;
  logic pop;
  logic q_valid;
  job_t push_job;
  job_t head;

  cs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .full     (full),
    .busy     (busy),
    .push     (push),
    .push_job (push_job)
  );

  cs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (full),
    .valid    (q_valid),
    .head     (head)
  );

  cs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .valid        (q_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== design/cs_front.sv =====
module cs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cs_pkg::in_t   item,
  input  logic          full,
  output logic          busy,
  output logic          push,
  output cs_pkg::job_t  push_job
);
  import cs_pkg::*;

  logic [PIXEL_BITS-1:0] min_seen;
  logic [PIXEL_BITS-1:0] max_seen;
  logic                  any_seen;
  logic [PIXEL_BITS-1:0] min_base;
  logic [PIXEL_BITS-1:0] max_base;
  logic [PIXEL_BITS-1:0] min_next;
  logic [PIXEL_BITS-1:0] max_next;
  logic [PIXEL_BITS-1:0] pix;
  logic [PIXEL_BITS-1:0] diff;
  logic                  accept;
  logic                  is_flat;

  assign busy   = full;
  assign accept = start && !busy;
  assign pix    = item.pixel_value;
  assign push   = accept && (item.req_type == REQ_MAP);

  always_comb begin
    min_base = item.first_of_plane ? MAX_CODE : min_seen;
    max_base = item.first_of_plane ? '0 : max_seen;
    min_next = (pix < min_base) ? pix : min_base;
    max_next = (pix > max_base) ? pix : max_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen <= MAX_CODE;
      max_seen <= '0;
      any_seen <= 1'b0;
    end else if (accept && (item.req_type == REQ_MEASURE)) begin
      min_seen <= min_next;
      max_seen <= max_next;
      any_seen <= 1'b1;
    end
  end

  assign is_flat = !any_seen || (max_seen <= min_seen);
  assign diff    = pix - min_seen;

  always_comb begin
    push_job.lo       = min_seen;
    push_job.hi       = max_seen;
    push_job.flat     = is_flat;
    push_job.num      = NUM_W'(diff) * NUM_W'(MAX_CODE);
    push_job.den      = max_seen - min_seen;
    push_job.need_div = 1'b0;
    push_job.quick    = '0;
    priority if (is_flat) begin
      push_job.quick = '0;
    end else if (pix <= min_seen) begin
      push_job.quick = '0;
    end else if (pix >= max_seen) begin
      push_job.quick = MAX_CODE;
    end else begin
      push_job.need_div = 1'b1;
    end
  end

endmodule

// ===== design/cs_queue.sv =====
module cs_queue #(
  parameter int DEPTH = cs_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cs_pkg::job_t  push_job,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output cs_pkg::job_t  head
);
  import cs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  job_t               mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_QW-1:0]  count;
  logic               do_pop;

  assign full   = (count == FULL_CNT);
  assign valid  = (count != '0);
  assign head   = mem[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && !full, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/cs_back.sv =====
module cs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  input  cs_pkg::job_t  head,
  output logic          pop,
  output logic          result_valid,
  output cs_pkg::out_t  result
);
  import cs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      step;
  logic [PIXEL_BITS-1:0] rem;
  logic [PIXEL_BITS-1:0] shift;
  logic [PIXEL_BITS-1:0] quot;
  logic [PIXEL_BITS-1:0] den;
  logic [PIXEL_BITS-1:0] lo;
  logic [PIXEL_BITS-1:0] hi;
  logic [PIXEL_BITS:0]   trial;
  logic                  ge;
  logic [PIXEL_BITS-1:0] rem_next;
  logic [PIXEL_BITS-1:0] quot_next;

  assign pop = (state == ST_IDLE) && valid;

  // One restoring division step per cycle; the remainder always stays below den.
  always_comb begin
    trial     = {rem, shift[PIXEL_BITS-1]};
    ge        = (trial >= {1'b0, den});
    rem_next  = ge ? PIXEL_BITS'(trial - {1'b0, den}) : trial[PIXEL_BITS-1:0];
    quot_next = {quot[PIXEL_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (valid) begin
            lo <= head.lo;
            hi <= head.hi;
            if (head.need_div) begin
              rem   <= head.num[NUM_W-1:PIXEL_BITS];
              shift <= head.num[PIXEL_BITS-1:0];
              den   <= head.den;
              quot  <= '0;
              step  <= '0;
              state <= ST_DIV;
            end else begin
              result.mapped_value <= head.quick;
              result.limit_low    <= head.lo;
              result.limit_high   <= head.hi;
              result.flat         <= head.flat;
              result_valid        <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          rem   <= rem_next;
          quot  <= quot_next;
          shift <= {shift[PIXEL_BITS-2:0], 1'b0};
          step  <= step + 1'b1;
          if (step == LAST_STEP) begin
            result.mapped_value <= quot_next;
            result.limit_low    <= lo;
            result.limit_high   <= hi;
            result.flat         <= 1'b0;
            result_valid        <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== test/contrast_stretch_min_max_tb.sv =====
module contrast_stretch_min_max_tb;
  import cs_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 260;

  class stretch_scoreboard;
    logic [PIXEL_BITS-1:0] low_lim;
    logic [PIXEL_BITS-1:0] high_lim;
    bit measured;
    out_t expected_px[$];
    int mismatches;

    function new();
      low_lim = MAX_CODE;
      high_lim = '0;
      measured = 0;
      mismatches = 0;
    endfunction

    function logic [PIXEL_BITS-1:0] stretched(logic [PIXEL_BITS-1:0] p);
      logic [NUM_W-1:0] num;
      if (p <= low_lim) return '0;
      if (p >= high_lim) return MAX_CODE;
      num = NUM_W'(p - low_lim) * NUM_W'(MAX_CODE);
      num = num / NUM_W'(high_lim - low_lim);
      if (num > NUM_W'(MAX_CODE)) return MAX_CODE;
      return num[PIXEL_BITS-1:0];
    endfunction

    function void take_item(in_t x);
      out_t r;
      if (x.req_type == REQ_MEASURE) begin
        if (x.first_of_plane) begin
          low_lim = MAX_CODE;
          high_lim = '0;
        end
        if (x.pixel_value < low_lim) low_lim = x.pixel_value;
        if (x.pixel_value > high_lim) high_lim = x.pixel_value;
        measured = 1;
      end else begin
        r.flat = !measured || (high_lim <= low_lim);
        r.mapped_value = r.flat ? '0 : stretched(x.pixel_value);
        r.limit_low = low_lim;
        r.limit_high = high_lim;
        expected_px.push_back(r);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: mapped=%0d low=%0d high=%0d flat=%0b",
                   got.mapped_value, got.limit_low, got.limit_high, got.flat);
        return;
      end
      want = expected_px.pop_front();
      if (got.mapped_value !== want.mapped_value || got.limit_low !== want.limit_low ||
          got.limit_high !== want.limit_high || got.flat !== want.flat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected mapped=%0d low=%0d high=%0d flat=%0b, %s%0d %0d %0d %0b",
                   want.mapped_value, want.limit_low, want.limit_high, want.flat,
                   "actual ", got.mapped_value, got.limit_low, got.limit_high, got.flat);
      end
    endfunction

    function int pending();
      return expected_px.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t item = '0;
  logic busy;
  logic result_valid;
  out_t result;

  stretch_scoreboard sb = new();
  int cycle_count = 0;

  contrast_stretch_min_max u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .result_valid(result_valid),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_result(result);
      if (start && !busy) sb.take_item(item);
    end
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic in_t make_item(logic req, logic [PIXEL_BITS-1:0] pix, logic first);
    in_t x;
    x.req_type = req;
    x.pixel_value = pix;
    x.first_of_plane = first;
    return x;
  endfunction

  task automatic send_item(input in_t x, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item <= x;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_planes(input int n_items, input int idle_pct);
    int sent;
    int lo;
    int span;
    int hi;
    int n_meas;
    int n_map;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(make_item(1'($urandom_range(1)), PIXEL_BITS'($urandom_range(255)),
                            1'($urandom_range(1))), idle_pct);
        sent++;
      end else begin
        lo = $urandom_range(255);
        case ($urandom_range(3))
          0: span = 0;
          1: span = $urandom_range(8);
          default: span = $urandom_range(255);
        endcase
        hi = (lo + span > 255) ? 255 : lo + span;
        n_meas = $urandom_range(1, 10);
        n_map = $urandom_range(1, 10);
        for (int i = 0; i < n_meas; i++) begin
          send_item(make_item(REQ_MEASURE, PIXEL_BITS'($urandom_range(hi, lo)),
                              (i == 0) && ($urandom_range(7) != 0)), idle_pct);
          sent++;
        end
        for (int i = 0; i < n_map; i++) begin
          send_item(make_item(REQ_MAP,
                              PIXEL_BITS'(($urandom_range(2) == 0) ? $urandom_range(255) :
                                          $urandom_range(hi, lo)),
                              1'($urandom_range(1))), idle_pct);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    send_item(make_item(REQ_MAP, 8'd77, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd200, 1'b1), 33);
    send_item(make_item(REQ_MEASURE, 8'd100, 1'b1), 33);
    send_item(make_item(REQ_MAP, 8'd100, 1'b0), 33);
    send_item(make_item(REQ_MEASURE, 8'd200, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd50, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd100, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd101, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd150, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd199, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd200, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd255, 1'b1), 33);
    send_item(make_item(REQ_MEASURE, 8'd0, 1'b1), 33);
    send_item(make_item(REQ_MAP, 8'd0, 1'b0), 33);
    send_item(make_item(REQ_MEASURE, 8'd255, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd0, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd1, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd128, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd254, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd255, 1'b0), 33);
    send_item(make_item(REQ_MEASURE, 8'd255, 1'b1), 33);
    send_item(make_item(REQ_MAP, 8'd255, 1'b0), 33);
    send_item(make_item(REQ_MEASURE, 8'd254, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd254, 1'b0), 33);
    send_item(make_item(REQ_MAP, 8'd255, 1'b0), 33);

    send_planes(RANDOM_ITEMS, 33);
    send_planes(RANDOM_ITEMS, 47);
    send_planes(RANDOM_ITEMS, 0);

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cs_pkg.sv
design/cs_front.sv
design/cs_queue.sv
design/cs_back.sv
design/contrast_stretch_min_max.sv
test/contrast_stretch_min_max_tb.sv
